### rtl/msrc_pkg.sv
// ============================================================================
// Modbus sensor response checker package
// Shared codes, widths, reset values and the result record for the checker.
// ============================================================================
package msrc_pkg;

    // Command codes carried by each input item.
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_BYTE    = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    // Phase codes, also used as the state encoding of the poll sequencer.
    localparam logic [1:0] PH_READY = 2'd0;
    localparam logic [1:0] PH_BUSY  = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    // Outcome codes.
    localparam logic [1:0] OC_VALID   = 2'd0;
    localparam logic [1:0] OC_TIMEOUT = 2'd1;
    localparam logic [1:0] OC_CRC     = 2'd2;
    localparam logic [1:0] OC_RANGE   = 2'd3;

    localparam int          CFG_W          = 16;
    localparam logic [15:0] CRC_PRESET     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] VALUE_MAX      = 16'h0168;
    localparam logic [7:0]  MIN_FRAME      = 8'd7;
    localparam logic [7:0]  COUNT_MAX      = 8'd255;
    localparam logic [7:0]  VALUE_HI_INDEX = 8'd5;
    localparam logic [7:0]  VALUE_LO_INDEX = 8'd6;
    localparam logic [7:0]  CRC_LAG        = 8'd2;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam int          TIMER_BITS_DEFAULT = 16;

    typedef struct packed {
        logic [1:0]  phase;
        logic [1:0]  outcome;
        logic [15:0] direction;
        logic        send_request;
    } t_result;

endpackage

### rtl/msrc_crc16_byte.sv
// ============================================================================
// CRC-16 byte step
// Folds one byte into a reflected CRC-16 (polynomial 0xA001), eight bit steps.
// ============================================================================
module msrc_crc16_byte (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (v_crc[0]) begin
                v_crc = (v_crc >> 1) ^ msrc_pkg::CRC_POLY;
            end else begin
                v_crc = v_crc >> 1;
            end
        end
        o_crc = v_crc;
    end

endmodule

### rtl/msrc_core.sv
// ============================================================================
// Poll sequencer and frame checker
// Holds the poll state and updates it for one item when fired.
// ============================================================================
module msrc_core #(
    parameter int TIMER_BITS = msrc_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [1:0]                 i_cmd,
    input  logic [7:0]                 i_rx_byte,
    input  logic                       i_frame_last,
    input  logic [msrc_pkg::CFG_W-1:0] i_timeout_ticks,
    output msrc_pkg::t_result          o_result
);

    localparam int CMP_W = (TIMER_BITS > msrc_pkg::CFG_W) ? TIMER_BITS : msrc_pkg::CFG_W;

    logic [1:0]            r_phase,   n_phase;
    logic [1:0]            r_outcome, n_outcome;
    logic [15:0]           r_crc,     n_crc;
    logic [7:0]            r_count,   n_count;
    logic [7:0]            r_dly0,    n_dly0;
    logic [7:0]            r_dly1,    n_dly1;
    logic [15:0]           r_value,   n_value;
    logic [TIMER_BITS-1:0] r_tick,    n_tick;
    logic [15:0]           w_crc_step;
    logic                  n_req;

    msrc_crc16_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (r_dly1),
        .o_crc  (w_crc_step)
    );

    always_comb begin
        n_phase   = r_phase;
        n_outcome = r_outcome;
        n_crc     = r_crc;
        n_count   = r_count;
        n_dly0    = r_dly0;
        n_dly1    = r_dly1;
        n_value   = r_value;
        n_tick    = r_tick;
        n_req     = 1'b0;
        case (i_cmd)
            msrc_pkg::CMD_START: begin
                if (r_phase == msrc_pkg::PH_READY) begin
                    n_phase   = msrc_pkg::PH_BUSY;
                    n_outcome = msrc_pkg::OC_TIMEOUT;
                    n_crc     = msrc_pkg::CRC_PRESET;
                    n_count   = '0;
                    n_dly0    = '0;
                    n_dly1    = '0;
                    n_value   = '0;
                    n_tick    = '0;
                    n_req     = 1'b1;
                end
            end
            msrc_pkg::CMD_BYTE: begin
                if (r_phase == msrc_pkg::PH_BUSY) begin
                    // The CRC lags two bytes so the trailing CRC never enters it.
                    if (r_count >= msrc_pkg::CRC_LAG) begin
                        n_crc = w_crc_step;
                    end
                    if (r_count == msrc_pkg::VALUE_HI_INDEX) begin
                        n_value = {i_rx_byte, 8'h00};
                    end else if (r_count == msrc_pkg::VALUE_LO_INDEX) begin
                        n_value = {r_value[15:8], i_rx_byte};
                    end
                    n_count = (r_count == msrc_pkg::COUNT_MAX) ? r_count : r_count + 8'd1;
                    if (i_frame_last) begin
                        if (n_count < msrc_pkg::MIN_FRAME || {i_rx_byte, r_dly0} != n_crc) begin
                            n_outcome = msrc_pkg::OC_CRC;
                        end else if (n_value > msrc_pkg::VALUE_MAX) begin
                            n_outcome = msrc_pkg::OC_RANGE;
                        end else begin
                            n_outcome = msrc_pkg::OC_VALID;
                        end
                        n_phase = msrc_pkg::PH_DONE;
                    end
                    n_dly1 = r_dly0;
                    n_dly0 = i_rx_byte;
                end
            end
            msrc_pkg::CMD_TICK: begin
                if (r_phase == msrc_pkg::PH_BUSY) begin
                    if (r_tick != {TIMER_BITS{1'b1}}) begin
                        n_tick = r_tick + 1'b1;
                    end
                    if (CMP_W'(n_tick) >= CMP_W'(i_timeout_ticks)) begin
                        n_outcome = msrc_pkg::OC_TIMEOUT;
                        n_phase   = msrc_pkg::PH_DONE;
                    end
                end
            end
            default: begin
                n_phase   = msrc_pkg::PH_READY;
                n_outcome = msrc_pkg::OC_TIMEOUT;
                n_crc     = msrc_pkg::CRC_PRESET;
                n_count   = '0;
                n_dly0    = '0;
                n_dly1    = '0;
                n_value   = '0;
                n_tick    = '0;
            end
        endcase
    end

    always_comb begin
        o_result.phase        = n_phase;
        o_result.outcome      = n_outcome;
        o_result.direction    = (n_outcome == msrc_pkg::OC_VALID) ? n_value : 16'h0000;
        o_result.send_request = n_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= msrc_pkg::PH_READY;
            r_outcome <= msrc_pkg::OC_TIMEOUT;
            r_crc     <= msrc_pkg::CRC_PRESET;
            r_count   <= '0;
            r_dly0    <= '0;
            r_dly1    <= '0;
            r_value   <= '0;
            r_tick    <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_outcome <= n_outcome;
            r_crc     <= n_crc;
            r_count   <= n_count;
            r_dly0    <= n_dly0;
            r_dly1    <= n_dly1;
            r_value   <= n_value;
            r_tick    <= n_tick;
        end
    end

endmodule

### rtl/modbus_sensor_response_checker_top.sv
// ============================================================================
// Modbus sensor response checker, top level
// Input register, poll sequencer with CRC-16 frame check, result register.
// ============================================================================
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  -------------------------------
//  in       to block   i_in_valid / o_in_stall    i_cmd, i_rx_byte, i_frame_last
//  out      from block o_out_valid / i_out_stall  o_phase, o_outcome, o_direction,
//                                                 o_send_request
//  cfg      to block   i_cfg_we                   i_cfg_wdata (timeout_ticks)
//
// Every item produces exactly one result item; it passes from the input
// register through the sequencer into the result register.
// One item per cycle is sustained unless the output stalls: the CRC byte step and
// the state update are one short stage between the input and result registers.
// The synchronous active-low reset clears the poll state, empties both
// registers and sets timeout_ticks to 1000.
// A stall on the output holds the result register; the input register then
// keeps one more item, and only when both are full is the input stalled.
module modbus_sensor_response_checker_top #(
    parameter int TIMER_BITS = msrc_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input item channel.
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_cmd,
    input  logic [7:0]                 i_rx_byte,
    input  logic                       i_frame_last,
    // Result item channel.
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_phase,
    output logic [1:0]                 o_outcome,
    output logic [15:0]                o_direction,
    output logic                       o_send_request,
    // Configuration write port.
    input  logic                       i_cfg_we,
    input  logic [msrc_pkg::CFG_W-1:0] i_cfg_wdata
);

    // Configuration register.
    logic [msrc_pkg::CFG_W-1:0] r_timeout;

    // Input register.
    logic       r_s1_vld;
    logic [1:0] r_s1_cmd;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;

    // Result register.
    logic              r_o_vld;
    msrc_pkg::t_result r_o_res;
    msrc_pkg::t_result w_res;

    logic w_out_can;
    logic w_s1_fire;
    logic w_in_acc;

    // The result register can take a new result when empty or being drained.
    assign w_out_can  = !r_o_vld || !i_out_stall;
    assign w_s1_fire  = r_s1_vld && w_out_can;
    assign o_in_stall = r_s1_vld && !w_out_can;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= msrc_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_cmd  <= i_cmd;
            r_s1_byte <= i_rx_byte;
            r_s1_last <= i_frame_last;
        end
    end

    // The sequencer commits its state only when the item moves on to the result register.
    msrc_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_s1_fire),
        .i_cmd           (r_s1_cmd),
        .i_rx_byte       (r_s1_byte),
        .i_frame_last    (r_s1_last),
        .i_timeout_ticks (r_timeout),
        .o_result        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_s1_fire) begin
            r_o_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_o_res <= w_res;
        end
    end

    assign o_out_valid    = r_o_vld;
    assign o_phase        = r_o_res.phase;
    assign o_outcome      = r_o_res.outcome;
    assign o_direction    = r_o_res.direction;
    assign o_send_request = r_o_res.send_request;

    // A held item in the input register is never dropped before it moves on.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !w_s1_fire |=> r_s1_vld)
        else $error("input register lost an item");

    // A request pulse only ever comes with the busy phase.
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_res.send_request |-> r_o_res.phase == msrc_pkg::PH_BUSY)
        else $error("request pulse outside busy");

    // A value is reported only with a valid outcome.
    a_dir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_res.outcome != msrc_pkg::OC_VALID |-> r_o_res.direction == 16'h0000)
        else $error("value reported without valid outcome");

    // A valid outcome means a finished poll with an in-range value.
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_res.outcome == msrc_pkg::OC_VALID |->
            r_o_res.phase == msrc_pkg::PH_DONE && r_o_res.direction <= msrc_pkg::VALUE_MAX)
        else $error("valid outcome inconsistent");

endmodule

### tb/sv/modbus_sensor_response_checker_top_tb.sv
// ============================================================================
// Modbus sensor response checker testbench
// Drives command, reply-byte and tick items into the checker and compares
// every result item with a cycle-free model of the poll sequencer, CRC-16
// frame check and tick timeout, under random idling on both channels.
// ============================================================================
module modbus_sensor_response_checker_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Width of the tick counter in the block as instantiated here.
    localparam int TIMER_W        = msrc_pkg::TIMER_BITS_DEFAULT;
    // Generous watchdog: a few times the slowest legal run.
    localparam int CYCLE_LIMIT    = 250000;
    // Length of the receiver hold-off that fills the block up.
    localparam int RX_HOLD_CYCLES = 400;
    // Cycles allowed after the last result for the two-stage pipeline.
    localparam int DRAIN_CYCLES   = 4;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic       frame_last;
    } t_poll_item;

    // ------------------------------------------------------------------------
    // Signals to and from the block. Every input has a known value at time 0.
    // ------------------------------------------------------------------------
    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_in_valid     = 1'b0;
    logic                        o_in_stall;
    logic [1:0]                  i_cmd          = msrc_pkg::CMD_RESTART;
    logic [7:0]                  i_rx_byte      = 8'h00;
    logic                        i_frame_last   = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_stall    = 1'b0;
    logic [1:0]                  o_phase;
    logic [1:0]                  o_outcome;
    logic [15:0]                 o_direction;
    logic                        o_send_request;
    logic                        i_cfg_we       = 1'b0;
    logic [msrc_pkg::CFG_W-1:0]  i_cfg_wdata    = '0;

    modbus_sensor_response_checker_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_rx_byte      (i_rx_byte),
        .i_frame_last   (i_frame_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_phase        (o_phase),
        .o_outcome      (o_outcome),
        .o_direction    (o_direction),
        .o_send_request (o_send_request),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared testbench state.
    // ------------------------------------------------------------------------
    t_poll_item          pending_items[$];     // items waiting to be offered
    msrc_pkg::t_result   expected_results[$];  // predictions, oldest first
    int                  items_queued    = 0;
    int                  items_sent      = 0;
    int                  results_checked = 0;
    int                  mismatches      = 0;
    int                  frame_outcomes[4] = '{default: 0};
    int                  idle_pct        = 0;  // chance per cycle to start a burst
    int                  tx_gap          = 0;
    int                  rx_gap          = 0;
    int                  rx_hold_left    = 0;
    logic                rx_hold_req     = 1'b0;
    int                  cycle_count     = 0;
    logic [1:0]          last_seen_phase = msrc_pkg::PH_READY;

    // Model of the poll sequencer, at the block's widths.
    logic [1:0]                 m_phase   = msrc_pkg::PH_READY;
    logic [15:0]                m_crc     = msrc_pkg::CRC_PRESET;
    logic [7:0]                 m_count   = 8'd0;
    logic [7:0]                 m_dly0    = 8'd0;  // newest byte
    logic [7:0]                 m_dly1    = 8'd0;  // byte before it
    logic [15:0]                m_value   = 16'd0;
    logic [TIMER_W-1:0]         m_ticks   = '0;
    logic [1:0]                 m_outcome = msrc_pkg::OC_TIMEOUT;
    logic [msrc_pkg::CFG_W-1:0] m_timeout = msrc_pkg::TIMEOUT_RESET;

    // ------------------------------------------------------------------------
    // Model helpers.
    // ------------------------------------------------------------------------

    // One byte of the reflected CRC-16, polynomial 0xA001.
    function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ msrc_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    // Start and restart both wipe the frame and fall back to a timeout outcome.
    function automatic void clear_poll_model();
        m_crc     = msrc_pkg::CRC_PRESET;
        m_count   = 8'd0;
        m_dly0    = 8'd0;
        m_dly1    = 8'd0;
        m_value   = 16'd0;
        m_ticks   = '0;
        m_outcome = msrc_pkg::OC_TIMEOUT;
    endfunction

    // Advance the model by one accepted item and return the result it causes.
    function automatic msrc_pkg::t_result predict_poll_result(logic [1:0] cmd,
                                                              logic [7:0] b,
                                                              logic last);
        msrc_pkg::t_result r;
        logic [7:0]        count_next;
        logic [15:0]       trailer;
        r.send_request = 1'b0;
        case (cmd)
            msrc_pkg::CMD_START: begin
                if (m_phase == msrc_pkg::PH_READY) begin
                    clear_poll_model();
                    m_phase        = msrc_pkg::PH_BUSY;
                    r.send_request = 1'b1;
                end
            end
            msrc_pkg::CMD_BYTE: begin
                if (m_phase == msrc_pkg::PH_BUSY) begin
                    // The CRC runs two bytes behind so the trailer stays out of it.
                    if (m_count >= msrc_pkg::CRC_LAG)
                        m_crc = crc16_step(m_crc, m_dly1);
                    if (m_count == msrc_pkg::VALUE_HI_INDEX)
                        m_value = {b, 8'h00};
                    else if (m_count == msrc_pkg::VALUE_LO_INDEX)
                        m_value[7:0] = b;
                    count_next = (m_count == msrc_pkg::COUNT_MAX) ? m_count
                                                                  : m_count + 8'd1;
                    if (last) begin
                        trailer = {b, m_dly0};
                        if (count_next < msrc_pkg::MIN_FRAME || trailer != m_crc)
                            m_outcome = msrc_pkg::OC_CRC;
                        else if (m_value > msrc_pkg::VALUE_MAX)
                            m_outcome = msrc_pkg::OC_RANGE;
                        else
                            m_outcome = msrc_pkg::OC_VALID;
                        m_phase = msrc_pkg::PH_DONE;
                    end
                    m_dly1  = m_dly0;
                    m_dly0  = b;
                    m_count = count_next;
                end
            end
            msrc_pkg::CMD_TICK: begin
                if (m_phase == msrc_pkg::PH_BUSY) begin
                    if (m_ticks != {TIMER_W{1'b1}})
                        m_ticks = m_ticks + 1'b1;
                    if (m_ticks >= m_timeout) begin
                        m_outcome = msrc_pkg::OC_TIMEOUT;
                        m_phase   = msrc_pkg::PH_DONE;
                    end
                end
            end
            default: begin
                clear_poll_model();
                m_phase = msrc_pkg::PH_READY;
            end
        endcase
        r.phase     = m_phase;
        r.outcome   = m_outcome;
        r.direction = (m_outcome == msrc_pkg::OC_VALID) ? m_value : 16'd0;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders. They only append to the pending queue.
    // ------------------------------------------------------------------------
    task automatic push_item(logic [1:0] cmd, logic [7:0] b, logic last);
        pending_items.push_back('{cmd: cmd, rx_byte: b, frame_last: last});
        items_queued++;
    endtask

    // A reply frame of len bytes. Frames of nine or more bytes carry the
    // chosen value at bytes 5 and 6; shorter ones get whatever lands there.
    // Ticks may be sprinkled between bytes, and an aborted frame is cut in
    // half and followed by a restart instead of a last byte.
    task automatic queue_frame(int len, bit good_crc, logic [15:0] value,
                               int tick_pct, bit abort);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        int          idx;
        int          stop;
        for (int i = 0; i < len - 2; i++)
            fb.push_back(8'($urandom_range(0, 255)));
        if (len >= 9) begin
            fb[msrc_pkg::VALUE_HI_INDEX] = value[15:8];
            fb[msrc_pkg::VALUE_LO_INDEX] = value[7:0];
        end
        if (len >= 2) begin
            crc = msrc_pkg::CRC_PRESET;
            foreach (fb[i])
                crc = crc16_step(crc, fb[i]);
            fb.push_back(crc[7:0]);
            fb.push_back(crc[15:8]);
        end else begin
            while (fb.size() < len)
                fb.push_back(8'($urandom_range(0, 255)));
        end
        if (!good_crc && fb.size() != 0) begin
            idx     = $urandom_range(0, fb.size() - 1);
            fb[idx] = fb[idx] ^ 8'(1 << $urandom_range(0, 7));
        end
        stop = abort ? fb.size() / 2 : fb.size();
        for (int i = 0; i < stop; i++) begin
            if ($urandom_range(0, 99) < tick_pct)
                repeat ($urandom_range(1, 3))
                    push_item(msrc_pkg::CMD_TICK, 8'($urandom), 1'b0);
            push_item(msrc_pkg::CMD_BYTE, fb[i], !abort && (i == fb.size() - 1));
        end
        if (abort)
            push_item(msrc_pkg::CMD_RESTART, 8'($urandom), 1'($urandom));
    endtask

    // One random poll: mostly well-formed start/reply/restart sequences with
    // random content, some stray items, bad CRCs, short frames and timeouts.
    task automatic queue_random_poll();
        int          pick;
        int          len;
        int          ticks;
        logic [15:0] value;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            push_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        end else begin
            push_item(msrc_pkg::CMD_START, 8'($urandom), 1'($urandom));
            if ($urandom_range(0, 9) == 0)
                push_item(msrc_pkg::CMD_START, 8'($urandom), 1'($urandom));
            if (pick < 14) begin
                // Tick-only poll; with a small limit it reaches or runs just past the timeout.
                ticks = (m_timeout <= 64) ? int'(m_timeout) + $urandom_range(0, 2)
                                          : $urandom_range(1, 30);
                repeat (ticks)
                    push_item(msrc_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:0]:   len = $urandom_range(250, 270);
                    [1:12]:  len = $urandom_range(1, 6);
                    [13:32]: len = $urandom_range(7, 8);
                    default: len = $urandom_range(9, 14);
                endcase
                case ($urandom_range(0, 5))
                    0:       value = 16'd0;
                    1:       value = msrc_pkg::VALUE_MAX;
                    2:       value = msrc_pkg::VALUE_MAX + 16'd1;
                    3:       value = 16'hFFFF;
                    4:       value = 16'($urandom_range(0, 400));
                    default: value = 16'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0, 1:    ticks = 0;
                    2:       ticks = 10;
                    default: ticks = 30;
                endcase
                queue_frame(len, $urandom_range(0, 99) < 85, value, ticks,
                            $urandom_range(0, 99) < 5);
            end
            // Stray items after the frame or ticks, which a finished poll must ignore.
            if ($urandom_range(0, 99) < 30)
                repeat ($urandom_range(1, 3))
                    push_item(2'($urandom_range(0, 2)), 8'($urandom), 1'($urandom));
            if ($urandom_range(0, 9) != 0)
                push_item(msrc_pkg::CMD_RESTART, 8'($urandom), 1'($urandom));
        end
    endtask

    // Wait until every queued item was taken and every result came back.
    // Every item yields a result, so the extra cycles are just margin.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write while the block is idle; the model follows at once.
    task automatic write_timeout(logic [msrc_pkg::CFG_W-1:0] ticks);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ticks;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        m_timeout    = ticks;
        @(posedge i_clk);
    endtask

    task automatic run_random_phase(logic [msrc_pkg::CFG_W-1:0] ticks, int pct,
                                    int item_goal);
        int goal;
        write_timeout(ticks);
        idle_pct = pct;
        // With idling off, any receiver burst still running ends first.
        while (idle_pct == 0 && (rx_gap != 0 || i_out_stall))
            @(posedge i_clk);
        goal     = items_queued + item_goal;
        while (items_queued < goal)
            queue_random_poll();
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers the pending items. A stalled item stays on the pins;
    // idle bursts only start between items, so valid never looks at stall.
    // The item on the pins is predicted at the edge where it is accepted.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_poll_item nxt;
        logic       holding;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap     <= 0;
        end else begin
            holding = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(
                    predict_poll_result(i_cmd, i_rx_byte, i_frame_last));
                items_sent++;
                holding = 1'b0;
            end
            if (!holding) begin
                if (tx_gap != 0) begin
                    tx_gap     <= tx_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() != 0 && idle_pct != 0 &&
                             $urandom_range(0, 99) < idle_pct) begin
                    // The burst starts in this cycle and lasts while tx_gap counts down.
                    tx_gap     <= $urandom_range(0, 17);
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    nxt           = pending_items.pop_front();
                    i_cmd        <= nxt.cmd;
                    i_rx_byte    <= nxt.rx_byte;
                    i_frame_last <= nxt.frame_last;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted on its own so that the sender keeps
    // offering items and the block has to stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            rx_hold_left <= 0;
        else if (rx_hold_req && rx_hold_left == 0)
            rx_hold_left <= RX_HOLD_CYCLES;
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // Receiver stall: the long hold-off, or random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_gap      <= 0;
        end else if (rx_hold_left != 0) begin
            i_out_stall <= 1'b1;
        end else if (rx_gap != 0) begin
            rx_gap      <= rx_gap - 1;
            i_out_stall <= 1'b1;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rx_gap      <= $urandom_range(0, 17);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: each accepted result is checked against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        msrc_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected (phase %0d)",
                                          o_phase));
            end else begin
                want = expected_results.pop_front();
                if (o_phase !== want.phase)
                    report_mismatch($sformatf("result %0d phase %0d, expected %0d",
                                              results_checked, o_phase, want.phase));
                if (o_outcome !== want.outcome)
                    report_mismatch($sformatf("result %0d outcome %0d, expected %0d",
                                              results_checked, o_outcome, want.outcome));
                if (o_direction !== want.direction)
                    report_mismatch($sformatf("result %0d value %0h, expected %0h",
                                              results_checked, o_direction,
                                              want.direction));
                if (o_send_request !== want.send_request)
                    report_mismatch($sformatf("result %0d request %0b, expected %0b",
                                              results_checked, o_send_request,
                                              want.send_request));
                // Tally how polls ended, once per entry into the finished phase.
                if (want.phase == msrc_pkg::PH_DONE && last_seen_phase != msrc_pkg::PH_DONE)
                    frame_outcomes[want.outcome]++;
                last_seen_phase = want.phase;
                results_checked++;
            end
        end
    end

    // Watchdog: a lost result or a stuck handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("modbus_sensor_response_checker_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        int base;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset timeout of 1000 ticks. Bytes and ticks in the
        // ready phase are ignored, as is a second start while busy. Then a
        // seven-byte frame whose value is made of its own CRC bytes, a
        // two-byte frame that is too short, and a full frame reading 361,
        // one past the allowed range.
        idle_pct = 20;
        push_item(msrc_pkg::CMD_BYTE, 8'hFF, 1'b1);
        push_item(msrc_pkg::CMD_TICK, 8'h00, 1'b0);
        push_item(msrc_pkg::CMD_RESTART, 8'h00, 1'b0);
        push_item(msrc_pkg::CMD_START, 8'h00, 1'b0);
        push_item(msrc_pkg::CMD_START, 8'hFF, 1'b1);
        queue_frame(7, 1'b1, 16'd0, 0, 1'b0);
        push_item(msrc_pkg::CMD_RESTART, 8'hFF, 1'b1);
        push_item(msrc_pkg::CMD_START, 8'h00, 1'b0);
        queue_frame(2, 1'b1, 16'd0, 0, 1'b0);
        push_item(msrc_pkg::CMD_RESTART, 8'h00, 1'b0);
        push_item(msrc_pkg::CMD_START, 8'h00, 1'b0);
        queue_frame(9, 1'b1, msrc_pkg::VALUE_MAX + 16'd1, 0, 1'b0);
        wait_drained();

        // Smallest limit: any tick in a poll ends it at once.
        run_random_phase(16'd1, 30, 220);
        wait_drained();

        // Largest limit, with one long frame that saturates the byte count.
        // Once items flow, the receiver holds off for a long stretch while
        // the sender keeps offering, so both internal stages fill up.
        run_random_phase(16'hFFFF, 15, 240);
        push_item(msrc_pkg::CMD_START, 8'h00, 1'b0);
        queue_frame(262, 1'b1, 16'd90, 0, 1'b0);
        push_item(msrc_pkg::CMD_RESTART, 8'h00, 1'b0);
        base = items_sent;
        while (items_sent < base + 20)
            @(posedge i_clk);
        rx_hold_req <= 1'b1;
        @(posedge i_clk);
        rx_hold_req <= 1'b0;
        wait_drained();

        // Short limit with heavy idling, so tick-only polls time out often.
        run_random_phase(16'd8, 45, 240);
        wait_drained();

        // Last part: no idling on either side.
        run_random_phase(16'd40, 0, 220);
        wait_drained();

        $display("Run covered %0d items and %0d checked results over timeout limits",
                 items_sent, results_checked);
        $display("1000, 1, 65535, 8 and 40; polls ended %0d valid, %0d timeout, %0d crc, %0d range",
                 frame_outcomes[msrc_pkg::OC_VALID], frame_outcomes[msrc_pkg::OC_TIMEOUT],
                 frame_outcomes[msrc_pkg::OC_CRC], frame_outcomes[msrc_pkg::OC_RANGE]);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("modbus_sensor_response_checker_top regression: pass");
        end else begin
            $display("modbus_sensor_response_checker_top regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/msrc_pkg.sv
rtl/msrc_crc16_byte.sv
rtl/msrc_core.sv
rtl/modbus_sensor_response_checker_top.sv
tb/sv/modbus_sensor_response_checker_top_tb.sv
